// ===== src/mexp_pkg.sv =====
// shared types and constants for the modular exponentiation unit
`default_nettype none
package mexp_pkg;

	localparam int MEXP_WIDTH = 32;
	localparam int FIELD_W    = 32;
	localparam int CFG_IDX_W  = 1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_EXPONENT = 1'b0;
	localparam cfg_idx_t REG_MODULUS  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_BIT,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} mexp_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mexp_mm_stat_t;

endpackage
`default_nettype wire

// ===== src/mexp_modmul.sv =====
// bit-serial shift-add-reduce modular multiplier, one multiplier bit per cycle
`default_nettype none
module mexp_modmul
	import mexp_pkg::*;
#(
	parameter int WIDTH = MEXP_WIDTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [WIDTH-1:0]   x,
	input  wire logic [WIDTH-1:0]   y,
	input  wire logic [WIDTH-1:0]   m,
	output mexp_mm_stat_t           stat,
	output logic      [WIDTH-1:0]   res
);

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0] r_q;
	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] y_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH+1:0] sum;
	logic [WIDTH+1:0] m1;
	logic [WIDTH+1:0] m2;
	logic [WIDTH-1:0] r_next;

	// r < m and y <= m + 1, so 2r + y stays below 3m
	assign m1  = {2'b00, m};
	assign m2  = {1'b0, m, 1'b0};
	assign sum = {1'b0, r_q, 1'b0} + (x_q[WIDTH-1] ? {2'b00, y_q} : '0);

	always_comb begin
		priority if (sum >= m2) begin
			r_next = WIDTH'(sum - m2);
		end else if (sum >= m1) begin
			r_next = WIDTH'(sum - m1);
		end else begin
			r_next = WIDTH'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			x_q <= x;
			y_q <= y;
		end else if (busy_q) begin
			r_q <= r_next;
			x_q <= {x_q[WIDTH-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign res       = r_q;

endmodule
`default_nettype wire

// ===== src/modular_exponentiation_unit.sv =====
// top level: right-to-left square-and-multiply modular exponentiation
//
// message_value is taken on a message_valid/message_ready beat; power_result
// leaves on a result_valid/result_ready beat. exponent and modulus are set
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// unit is idle, which the unit itself does not enforce. one item is worked on
// at a time: message_ready is high only when the sequencer is idle. an item
// costs one reduction pass of the message, then for each exponent bit up to
// the highest set bit an ST_BIT step plus the modular multiplies: a multiply
// for a set bit, a square for every bit but the highest. short exponents
// need fewer multiplies. a zero modulus gives 0 with no multiply.
// the result sits in an output register; while it waits on a stalled
// receiver the next item runs, then holds in the sequencer, and no new beat
// is taken until the waiting result has gone.
// reset clears the sequencer and the output valid flag and sets exponent and
// modulus to 1.
`default_nettype none
module modular_exponentiation_unit
	import mexp_pkg::*;
#(
	parameter int WIDTH = MEXP_WIDTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire cfg_idx_t           cfg_index,
	input  wire logic [FIELD_W-1:0] cfg_data,
	input  wire logic               message_valid,
	output logic                    message_ready,
	input  wire logic [FIELD_W-1:0] message_value,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic      [FIELD_W-1:0] power_result
);

	mexp_state_t      state_q;
	mexp_state_t      state_d;

	logic [WIDTH-1:0] exponent_q;
	logic [WIDTH-1:0] modulus_q;
	logic [WIDTH-1:0] e_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] b_q;
	logic [FIELD_W-1:0] power_result_q;
	logic             res_valid_q;

	logic             mm_start;
	logic [WIDTH-1:0] mm_x;
	logic [WIDTH-1:0] mm_y;
	logic [WIDTH-1:0] mm_res;
	mexp_mm_stat_t    mm_stat;

	logic             accept;
	logic             mod_zero;
	logic             e_rest_zero;
	logic             hand_over;

	assign accept      = message_valid && message_ready;
	assign mod_zero    = (modulus_q == '0);
	assign e_rest_zero = (e_q[WIDTH-1:1] == '0);
	assign hand_over   = !res_valid_q || result_ready;

	mexp_modmul #(
		.WIDTH (WIDTH)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.x      (mm_x),
		.y      (mm_y),
		.m      (modulus_q),
		.stat   (mm_stat),
		.res    (mm_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (message_valid) begin
					state_d = mod_zero ? ST_DONE : ST_RED;
				end
			end
			ST_RED: begin
				if (mm_stat.done) begin
					state_d = (mm_res == '0 || e_q == '0) ? ST_DONE : ST_BIT;
				end
			end
			ST_BIT: begin
				state_d = e_q[0] ? ST_MUL : ST_SQR;
			end
			ST_MUL: begin
				if (mm_stat.done) begin
					state_d = e_rest_zero ? ST_DONE : ST_SQR;
				end
			end
			ST_SQR: begin
				if (mm_stat.done) begin
					state_d = e_rest_zero ? ST_DONE : ST_BIT;
				end
			end
			ST_DONE: begin
				if (hand_over) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		message_ready = (state_q == ST_IDLE);
		mm_start      = 1'b0;
		mm_x          = b_q;
		mm_y          = b_q;
		unique case (state_q)
			ST_IDLE: begin
				mm_start = message_valid && !mod_zero;
				mm_x     = message_value[WIDTH-1:0];
				mm_y     = WIDTH'(1);
			end
			ST_BIT: begin
				mm_start = 1'b1;
				mm_x     = e_q[0] ? acc_q : b_q;
			end
			ST_MUL: begin
				mm_start = mm_stat.done && !e_rest_zero;
			end
			ST_RED, ST_SQR, ST_DONE: begin
				mm_start = 1'b0;
			end
			default: mm_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			exponent_q  <= WIDTH'(1);
			modulus_q   <= WIDTH'(1);
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_EXPONENT: exponent_q <= cfg_data[WIDTH-1:0];
					REG_MODULUS:  modulus_q  <= cfg_data[WIDTH-1:0];
					default:      exponent_q <= exponent_q;
				endcase
			end
			if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == ST_DONE && hand_over) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_q <= exponent_q;
			if (mod_zero) begin
				acc_q <= '0;
			end
		end
		if (state_q == ST_RED && mm_stat.done) begin
			b_q   <= mm_res;
			acc_q <= (mm_res == '0) ? '0 : WIDTH'(1);
		end
		if (state_q == ST_MUL && mm_stat.done) begin
			acc_q <= mm_res;
		end
		if (state_q == ST_SQR && mm_stat.done) begin
			b_q <= mm_res;
			e_q <= {1'b0, e_q[WIDTH-1:1]};
		end
		if (state_q == ST_DONE && hand_over) begin
			power_result_q <= FIELD_W'(acc_q);
		end
	end

	assign result_valid = res_valid_q;
	assign power_result = power_result_q;

	a_idle_mm_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mm_stat.busy)
		else $error("multiplier busy while sequencer idle");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mm_stat.done |-> (state_q == ST_RED || state_q == ST_MUL || state_q == ST_SQR))
		else $error("multiplier finished outside a wait state");

	a_res_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(mm_stat.done && !mod_zero) |-> (mm_res < modulus_q))
		else $error("multiplier result not reduced");

	a_start_idle_mm: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |-> !mm_stat.busy)
		else $error("multiplier restarted while busy");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the modular exponentiation unit
`timescale 1ns / 1ps
module testbench
	import mexp_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 2400;
	localparam int HOLD_CYCLES    = 3000;

	typedef struct {
		logic [FIELD_W-1:0] message;
		logic [FIELD_W-1:0] power;
	} power_entry_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	cfg_idx_t           cfg_index = REG_EXPONENT;
	logic [FIELD_W-1:0] cfg_data = '0;
	logic               message_valid = 1'b0;
	logic               message_ready;
	logic [FIELD_W-1:0] message_value = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [FIELD_W-1:0] power_result;

	power_entry_t       pending_powers[$];
	power_entry_t       head_entry;
	logic [FIELD_W-1:0] key_exponent = 1;
	logic [FIELD_W-1:0] key_modulus = 1;
	int                 sender_idle_pct = 0;
	int                 receiver_idle_pct = 0;
	bit                 hold_off_start = 1'b0;
	int                 hold_off_count = 0;
	int                 idle_cycles = 0;
	int                 fail_count = 0;
	int                 messages_sent = 0;
	int                 results_checked = 0;
	int                 keys_loaded = 0;

	modular_exponentiation_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.message_valid (message_valid),
		.message_ready (message_ready),
		.message_value (message_value),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.power_result  (power_result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// right-to-left square and multiply on 64-bit products
	function automatic logic [FIELD_W-1:0] mod_power(input logic [FIELD_W-1:0] value,
			input logic [FIELD_W-1:0] exponent_value, input logic [FIELD_W-1:0] modulus_value);
		logic [63:0] base;
		logic [63:0] acc;
		logic [63:0] modulus_wide;
		modulus_wide = {32'd0, modulus_value};
		if (modulus_value == 0)
			return '0;
		base = {32'd0, value} % modulus_wide;
		if (base == 0)
			return '0;
		acc = 64'd1;
		for (int i = 0; i < MEXP_WIDTH; i++) begin
			if (exponent_value[i])
				acc = (acc * base) % modulus_wide;
			base = (base * base) % modulus_wide;
		end
		return acc[FIELD_W-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] random_exponent();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return $urandom_range(1, 15);
			4, 5: return $urandom_range(16, 16'hFFFF);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [FIELD_W-1:0] random_modulus();
		case ($urandom_range(9))
			0: return 1;
			1: return '1;
			2: return $urandom_range(2, 255);
			3: return {1'b1, 31'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [FIELD_W-1:0] random_message();
		logic [63:0] multiple;
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: begin
				if (key_modulus == 0)
					return $urandom;
				multiple = {32'd0, key_modulus} *
					{32'd0, 32'($urandom_range(0, 32'hFFFF_FFFF / key_modulus))};
				return multiple[FIELD_W-1:0];
			end
			3: return key_modulus - 1;
			4: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		fail_count++;
	endtask

	// called at a rising edge; returns at the edge that takes the beat
	task automatic send_message(input logic [FIELD_W-1:0] value);
		power_entry_t entry;
		while ($urandom_range(99) < sender_idle_pct) begin
			message_valid <= 1'b0;
			@(posedge clk);
		end
		message_valid <= 1'b1;
		message_value <= value;
		@(posedge clk);
		while (!message_ready)
			@(posedge clk);
		entry.message = value;
		entry.power = mod_power(value, key_exponent, key_modulus);
		pending_powers.push_back(entry);
		messages_sent++;
	endtask

	task automatic settle();
		message_valid <= 1'b0;
		while (pending_powers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_key(input logic [FIELD_W-1:0] exponent_value,
			input logic [FIELD_W-1:0] modulus_value);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_EXPONENT;
		cfg_data  <= exponent_value;
		@(posedge clk);
		cfg_index <= REG_MODULUS;
		cfg_data  <= modulus_value;
		@(posedge clk);
		cfg_we <= 1'b0;
		key_exponent = exponent_value;
		key_modulus  = modulus_value;
		keys_loaded++;
	endtask

	task automatic run_random_keys(input int key_count, input int per_key);
		repeat (key_count) begin
			load_key(random_exponent(), random_modulus());
			repeat (per_key) send_message(random_message());
		end
	endtask

	task automatic test_directed();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		// reset key: modulus one
		send_message('0);
		send_message('1);
		// exponent zero
		load_key('0, '1);
		send_message('0);
		send_message('1);
		send_message(32'd5);
		load_key('1, 32'hFFFF_FFFB);
		send_message('1);
		send_message(32'd1);
		send_message(32'd2);
		send_message(32'hFFFF_FFFA);
		send_message(32'hFFFF_FFFB);
		load_key(32'd65537, 32'd3233);
		send_message(32'd65);
		send_message(32'd6466);
		send_message('1);
		// zero modulus
		load_key(32'd17, '0);
		send_message(32'd123);
		send_message('0);
		load_key(32'h8000_0000, 32'h8000_0000);
		send_message(32'd3);
		send_message(32'h8000_0000);
		load_key(32'd2, 32'd2);
		send_message(32'hAAAA_AAAA);
		send_message(32'h5555_5555);
	endtask

	task automatic test_slow_receiver();
		sender_idle_pct = 7;
		receiver_idle_pct = 85;
		run_random_keys(5, 20);
	endtask

	task automatic test_slow_sender();
		sender_idle_pct = 85;
		receiver_idle_pct = 7;
		run_random_keys(5, 18);
	endtask

	task automatic test_full_rate();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		run_random_keys(5, 15);
	endtask

	task automatic test_result_stall();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		load_key(32'd65537, 32'd3233);
		hold_off_start = 1'b1;
		repeat (8) send_message(random_message());
	endtask

	// result side: check each beat, then pick ready for the next edge
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_powers.size() == 0) begin
				report_mismatch($sformatf("power_result %h with no message outstanding",
					power_result));
			end else begin
				head_entry = pending_powers.pop_front();
				results_checked++;
				if (power_result !== head_entry.power)
					report_mismatch($sformatf("message %h: power_result %h, want %h",
						head_entry.message, power_result, head_entry.power));
			end
		end
		if (hold_off_start) begin
			hold_off_start = 1'b0;
			hold_off_count = HOLD_CYCLES;
		end
		if (hold_off_count > 0) begin
			hold_off_count--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (message_valid && message_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] timeout: no beat for %0d cycles", $realtime, idle_cycles);
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_slow_receiver();
		test_slow_sender();
		test_full_rate();
		test_result_stall();
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_powers.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_powers.size()));
		$display("run covered %0d message beats under %0d key settings, %0d results checked",
			messages_sent, keys_loaded, results_checked);
		$display("idling: slow receiver, slow sender, full rate and one long result stall");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/mexp_pkg.sv
src/mexp_modmul.sv
src/modular_exponentiation_unit.sv
verif/testbench.sv
